@@ design/asmt_pkg.sv @@
// Shared types, constants and lookup functions of the assembly source tokenizer
`timescale 1ns / 1ps

package asmt_pkg;

  // default widths of the position, length and line counters
  localparam int unsigned POS_BITS_DEF  = 16;
  localparam int unsigned LEN_BITS_DEF  = 10;
  localparam int unsigned LINE_BITS_DEF = 16;

  // code given to tokens that are not keywords
  localparam logic [7:0] NO_CODE = 8'hFF;

  // token kinds as seen on the output
  typedef enum logic [3:0] {
    KIND_EOF    = 4'd0,
    KIND_ERROR  = 4'd1,
    KIND_IDENT  = 4'd2,
    KIND_REG    = 4'd3,
    KIND_MNEM   = 4'd4,
    KIND_NUM    = 4'd5,
    KIND_DIR    = 4'd6,
    KIND_DOLLAR = 4'd7,
    KIND_POUND  = 4'd8,
    KIND_COMMA  = 4'd9,
    KIND_COLON  = 4'd10,
    KIND_LT     = 4'd11,
    KIND_GT     = 4'd12
  } tok_kind_e;

  // result of a keyword lookup
  typedef struct packed {
    logic       is_reg;
    logic       is_op;
    logic [7:0] code;
  } kw_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c == "_") || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // exact match of up to three held characters, first character in the high byte,
  // unused bytes zero
  function automatic kw_t kw_lookup(input logic [23:0] head);
    kw_t r;
    r = '{1'b0, 1'b0, NO_CODE};
    unique case (head)
      // register names
      {"r0", 8'h00}:   r = '{1'b1, 1'b0, 8'h00};
      {"r1", 8'h00}:   r = '{1'b1, 1'b0, 8'h01};
      {"r2", 8'h00}:   r = '{1'b1, 1'b0, 8'h02};
      {"r3", 8'h00}:   r = '{1'b1, 1'b0, 8'h03};
      {"r4", 8'h00}:   r = '{1'b1, 1'b0, 8'h04};
      {"r5", 8'h00}:   r = '{1'b1, 1'b0, 8'h05};
      {"r6", 8'h00}:   r = '{1'b1, 1'b0, 8'h06};
      {"r7", 8'h00}:   r = '{1'b1, 1'b0, 8'h07};
      {"st", 8'h00}:   r = '{1'b1, 1'b0, 8'h08};
      {"as", 8'h00}:   r = '{1'b1, 1'b0, 8'h09};
      {"ds", 8'h00}:   r = '{1'b1, 1'b0, 8'h0A};
      {"xl", 8'h00}:   r = '{1'b1, 1'b0, 8'h0B};
      {"xh", 8'h00}:   r = '{1'b1, 1'b0, 8'h0C};
      {"yl", 8'h00}:   r = '{1'b1, 1'b0, 8'h0D};
      {"yh", 8'h00}:   r = '{1'b1, 1'b0, 8'h0E};
      {"x", 16'h0000}: r = '{1'b1, 1'b0, 8'hF0};
      {"y", 16'h0000}: r = '{1'b1, 1'b0, 8'hF1};
      // mnemonics
      "nop":           r = '{1'b0, 1'b1, 8'h00};
      "jmp":           r = '{1'b0, 1'b1, 8'h10};
      "inc":           r = '{1'b0, 1'b1, 8'h20};
      "dec":           r = '{1'b0, 1'b1, 8'h30};
      "clc":           r = '{1'b0, 1'b1, 8'h40};
      "sec":           r = '{1'b0, 1'b1, 8'h50};
      "not":           r = '{1'b0, 1'b1, 8'h60};
      "jsr":           r = '{1'b0, 1'b1, 8'h70};
      "ret":           r = '{1'b0, 1'b1, 8'h80};
      "beq":           r = '{1'b0, 1'b1, 8'h01};
      "bne":           r = '{1'b0, 1'b1, 8'h11};
      "blt":           r = '{1'b0, 1'b1, 8'h21};
      "ble":           r = '{1'b0, 1'b1, 8'h31};
      "bgt":           r = '{1'b0, 1'b1, 8'h41};
      "bge":           r = '{1'b0, 1'b1, 8'h51};
      "mov":           r = '{1'b0, 1'b1, 8'h02};
      "add":           r = '{1'b0, 1'b1, 8'h03};
      "adc":           r = '{1'b0, 1'b1, 8'h43};
      "sub":           r = '{1'b0, 1'b1, 8'h04};
      "sbb":           r = '{1'b0, 1'b1, 8'h44};
      "cmp":           r = '{1'b0, 1'b1, 8'h05};
      "and":           r = '{1'b0, 1'b1, 8'h07};
      {"or", 8'h00}:   r = '{1'b0, 1'b1, 8'h47};
      "psh":           r = '{1'b0, 1'b1, 8'h08};
      "pop":           r = '{1'b0, 1'b1, 8'h48};
      "dbg":           r = '{1'b0, 1'b1, 8'hFE};
      "end":           r = '{1'b0, 1'b1, 8'hFF};
      default:         r = '{1'b0, 1'b0, NO_CODE};
    endcase
    return r;
  endfunction

endpackage

@@ design/assembly_source_tokenizer_top.sv @@
// Top level of the assembly source tokenizer
`timescale 1ns / 1ps

// Streaming scanner for a small assembly language. Source bytes enter on the
// input channel (in_valid_i / in_ready_o), one character per transaction, with
// end_of_source_i or a zero byte marking the end of the input. Tokens leave on
// the output channel (out_valid_o / out_ready_i), one token per transaction,
// with kind, start position, length, line, keyword code and last_of_run_o set
// on the final token caused by a character.
// A character is registered on acceptance and scanned once the queue has two
// free entries; the tokens it causes are written into the queue as it is
// scanned and reach the output from there. A token that spans several
// characters enters the queue when the character ending it is scanned.
// One character is accepted every cycle while the four-entry token queue has
// two free entries; tokens leave at one per cycle while out_ready_i is high,
// so the output rate sets the sustained rate when characters cause more than
// one token each. At reset the queue empties, the position returns to zero
// and the line to one, as both also do at every end of input. When the
// receiver stalls, the queue fills and in_ready_o drops until entries are freed.

module assembly_source_tokenizer_top #(
  parameter int unsigned POS_BITS  = asmt_pkg::POS_BITS_DEF,
  parameter int unsigned LEN_BITS  = asmt_pkg::LEN_BITS_DEF,
  parameter int unsigned LINE_BITS = asmt_pkg::LINE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_in_i,
  input  logic                 end_of_source_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           token_kind_o,
  output logic [POS_BITS-1:0]  start_pos_o,
  output logic [LEN_BITS-1:0]  token_length_o,
  output logic [LINE_BITS-1:0] line_number_o,
  output logic [7:0]           keyword_code_o,
  output logic                 last_of_run_o
);
  import asmt_pkg::*;

  localparam int unsigned TOK_W = 1 + 4 + POS_BITS + LEN_BITS + LINE_BITS + 8;

  logic             in_valid_q;
  logic [7:0]       char_q;
  logic             eos_q;
  logic             step, space2;
  logic             push0, push1;
  logic [TOK_W-1:0] tok0, tok1, head_tok;

  // input register, drained when the queue can take two tokens
  assign step       = in_valid_q && space2;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
      eos_q  <= end_of_source_i;
    end
  end

  // scanner
  asmt_scan #(
    .POS_BITS (POS_BITS),
    .LEN_BITS (LEN_BITS),
    .LINE_BITS(LINE_BITS),
    .TOK_W    (TOK_W)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (char_q),
    .eos_i  (eos_q),
    .push0_o(push0),
    .push1_o(push1),
    .tok0_o (tok0),
    .tok1_o (tok1)
  );

  // token queue
  asmt_fifo #(
    .W(TOK_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .data0_i (tok0),
    .data1_i (tok1),
    .pop_i   (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (head_tok),
    .space2_o(space2)
  );

  // unpack the head token onto the ports
  assign {last_of_run_o, token_kind_o, start_pos_o, token_length_o,
          line_number_o, keyword_code_o} = head_tok;

endmodule

@@ design/asmt_scan.sv @@
// Scanner state and token generation, up to two tokens per character
`timescale 1ns / 1ps

module asmt_scan #(
  parameter int unsigned POS_BITS  = asmt_pkg::POS_BITS_DEF,
  parameter int unsigned LEN_BITS  = asmt_pkg::LEN_BITS_DEF,
  parameter int unsigned LINE_BITS = asmt_pkg::LINE_BITS_DEF,
  parameter int unsigned TOK_W     = 1 + 4 + POS_BITS + LEN_BITS + LINE_BITS + 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       char_i,
  input  logic             eos_i,
  output logic             push0_o,
  output logic             push1_o,
  output logic [TOK_W-1:0] tok0_o,
  output logic [TOK_W-1:0] tok1_o
);
  import asmt_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_NUM   = 2'd2,
    MODE_DIR   = 2'd3
  } mode_e;

  localparam logic [POS_BITS-1:0]  PosMax  = '1;
  localparam logic [LEN_BITS-1:0]  LenMax  = '1;
  localparam logic [LINE_BITS-1:0] LineMax = '1;

  mode_e                mode_q, mode_d;
  logic [POS_BITS-1:0]  pos_q, pos_d;
  logic [POS_BITS-1:0]  start_q, start_d;
  logic [LEN_BITS-1:0]  len_q, len_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [23:0]          head_q, head_d;

  logic      eos_any, letter, digit, cont, short_tok, ws, nl, starts_tok;
  kw_t       kw;
  tok_kind_e pend_kind, sec_kind, punct_kind;
  logic      pend_v, sec_v;
  logic [7:0] pend_code;
  logic [LEN_BITS-1:0] sec_len;

  // character classes
  assign eos_any    = eos_i || (char_i == 8'h00);
  assign letter     = is_letter(char_i);
  assign digit      = is_digit(char_i);
  assign nl         = (char_i == 8'h0A);
  assign ws         = (char_i == 8'h20) || (char_i == 8'h0D) || (char_i == 8'h09);
  assign starts_tok = letter || digit || (char_i == ".");

  // does the character extend the open token
  always_comb begin
    unique case (mode_q)
      MODE_IDLE:  cont = 1'b0;
      MODE_NUM:   cont = digit;
      MODE_IDENT: cont = letter || digit;
      MODE_DIR:   cont = letter || digit;
      default:    cont = 1'b0;
    endcase
  end

  // classify the open token
  assign kw        = kw_lookup(head_q);
  assign short_tok = (len_q <= LEN_BITS'(3));

  always_comb begin
    pend_code = NO_CODE;
    unique case (mode_q)
      MODE_IDENT: begin
        if (short_tok && kw.is_reg) begin
          pend_kind = KIND_REG;
          pend_code = kw.code;
        end else if (short_tok && kw.is_op) begin
          pend_kind = KIND_MNEM;
          pend_code = kw.code;
        end else begin
          pend_kind = KIND_IDENT;
        end
      end
      MODE_NUM:  pend_kind = KIND_NUM;
      MODE_DIR:  pend_kind = KIND_DIR;
      MODE_IDLE: pend_kind = KIND_IDENT;
      default:   pend_kind = KIND_IDENT;
    endcase
  end

  // single-character tokens
  always_comb begin
    unique case (char_i)
      "$":     punct_kind = KIND_DOLLAR;
      "#":     punct_kind = KIND_POUND;
      ",":     punct_kind = KIND_COMMA;
      ":":     punct_kind = KIND_COLON;
      "<":     punct_kind = KIND_LT;
      ">":     punct_kind = KIND_GT;
      default: punct_kind = KIND_ERROR;
    endcase
  end

  // which tokens this character causes
  assign pend_v   = (mode_q != MODE_IDLE) && (eos_any || !cont);
  assign sec_v    = eos_any || (!cont && !nl && !ws && !starts_tok);
  assign sec_kind = eos_any ? KIND_EOF : punct_kind;
  assign sec_len  = eos_any ? '0 : LEN_BITS'(1);

  assign push0_o = step_i && (pend_v || sec_v);
  assign push1_o = step_i && pend_v && sec_v;
  assign tok0_o  = pend_v ? {!sec_v, pend_kind, start_q, len_q, line_q, pend_code}
                          : {1'b1, sec_kind, pos_q, sec_len, line_q, NO_CODE};
  assign tok1_o  = {1'b1, sec_kind, pos_q, sec_len, line_q, NO_CODE};

  // next scanner state
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    line_d  = line_q;
    head_d  = head_q;
    if (step_i) begin
      if (eos_any) begin
        mode_d  = MODE_IDLE;
        pos_d   = '0;
        start_d = '0;
        len_d   = '0;
        line_d  = LINE_BITS'(1);
        head_d  = '0;
      end else begin
        if (cont) begin
          if (len_q == LEN_BITS'(1)) head_d[15:8] = char_i;
          if (len_q == LEN_BITS'(2)) head_d[7:0]  = char_i;
          if (len_q != LenMax) len_d = len_q + LEN_BITS'(1);
        end else begin
          mode_d = MODE_IDLE;
          if (nl) begin
            if (line_q != LineMax) line_d = line_q + LINE_BITS'(1);
          end else if (starts_tok) begin
            mode_d  = letter ? MODE_IDENT : (digit ? MODE_NUM : MODE_DIR);
            start_d = pos_q;
            len_d   = LEN_BITS'(1);
            head_d  = {char_i, 16'h0000};
          end
        end
        if (pos_q != PosMax) pos_d = pos_q + POS_BITS'(1);
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      line_q  <= LINE_BITS'(1);
      head_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      line_q  <= line_d;
      head_q  <= head_d;
    end
  end

`ifndef SYNTH
  // end of input puts the scanner back to its reset state
  a_eos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && eos_any) |=> (mode_q == MODE_IDLE) && (pos_q == '0) && (line_q == LINE_BITS'(1)))
    else $error("scanner not restarted after end of input");

  // a character that extends a token produces nothing
  a_cont_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !eos_any && cont) |-> !push0_o)
    else $error("token emitted on continuing character");

  // with no open token a character gives at most one token
  a_idle_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (mode_q == MODE_IDLE)) |-> !push1_o)
    else $error("two tokens from idle state");
`endif

endmodule

@@ design/asmt_fifo.sv @@
// Four-entry token queue with up to two writes and one read per cycle
`timescale 1ns / 1ps

module asmt_fifo #(
  parameter int unsigned W = 55
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push0_i,
  input  logic         push1_i,
  input  logic [W-1:0] data0_i,
  input  logic [W-1:0] data1_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  output logic         space2_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;

  assign valid_o  = (cnt_q != '0);
  assign data_o   = mem_q[rd_ptr_q];
  assign space2_o = (cnt_q <= CNT_W'(DEPTH - 2));
  assign pop      = pop_i && valid_o;

  // token storage
  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wr_ptr_q] <= data0_i;
    if (push1_i) mem_q[wr_ptr_q + PTR_W'(1)] <= data1_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push0_i) + PTR_W'(push1_i);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      cnt_q    <= cnt_q + CNT_W'(push0_i) + CNT_W'(push1_i) - CNT_W'(pop);
    end
  end

`ifndef SYNTH
  // the second write port is only used together with the first
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i)
    else $error("second write without first");

  // writes only arrive when two entries are free
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0_i |-> (cnt_q <= CNT_W'(DEPTH - 2)))
    else $error("token queue overflow");

  // fill count follows writes and reads
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q == $past(cnt_q) + CNT_W'($past(push0_i)) + CNT_W'($past(push1_i))
              - CNT_W'($past(pop))))
    else $error("fill count mismatch");
`endif

endmodule
